/* hdl/calendar_clock_with_periodic_alarms_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the calendar clock unit
// Shared property templates. Each one is clocked on clk and disabled while
// rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_WITH_PERIODIC_ALARMS_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_PERIODIC_ALARMS_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CCPA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CCPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ccpa_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar clock package
// Widths, operation and register codes, payload types and calendar helper
// functions shared by the calendar clock unit.
// ----------------------------------------------------------------------------
package ccpa_pkg;

    // Alarm slots and configuration port
    localparam int SLOT_COUNT         = 4;
    localparam int NUM_ALARMS_DEFAULT = 4;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 32;
    localparam int INTERVAL_W         = 32;

    // Seconds added by one tick
    localparam int SECONDS_PER_TICK = 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    // Field limits
    localparam int SEC_PER_MIN = 60;
    localparam int SEC_MAX     = 59;
    localparam int MIN_MAX     = 59;
    localparam int HOUR_MAX    = 23;
    localparam int DAY_MAX     = 30;
    localparam int MONTH_MAX   = 11;
    localparam int YEAR_MAX    = 9999;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME = 2'd1;
    localparam logic [OP_W-1:0] OP_COLLECT  = 2'd2;

    // Register indexes; interval registers follow the enable register in slot order
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_0   = 3'd1;

    // Zero-based month numbers that have short lengths
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;

    // Month lengths
    localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

    // Divisibility by 25 over a 14-bit year: multiply by the inverse of 25
    // modulo 2^14 and the year is a multiple of 25 exactly when the low
    // product bits do not exceed floor((2^14 - 1) / 25).
    localparam logic [YEAR_W-1:0] YEAR_INV25        = 14'd7209;
    localparam logic [YEAR_W-1:0] YEAR_DIV25_LIMIT  = 14'd655;

    // Input request
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SEC_W-1:0]   new_second;
        logic [MIN_W-1:0]   new_minute;
        logic [HOUR_W-1:0]  new_hour;
        logic [DAY_W-1:0]   new_day;
        logic [MONTH_W-1:0] new_month;
        logic [YEAR_W-1:0]  new_year;
    } ccpa_in_t;

    // Result
    typedef struct packed {
        logic [SEC_W-1:0]      second_now;
        logic [MIN_W-1:0]      minute_now;
        logic [HOUR_W-1:0]     hour_now;
        logic [DAY_W-1:0]      day_now;
        logic [MONTH_W-1:0]    month_now;
        logic [YEAR_W-1:0]     year_now;
        logic [SLOT_COUNT-1:0] alarms_fired;
    } ccpa_out_t;

    // Calendar time
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } ccpa_time_t;

    // Decoded request controls for the datapath blocks
    typedef struct packed {
        logic advance;
        logic tick;
        logic load_time;
        logic collect;
    } ccpa_ctrl_t;

    // Gregorian leap rule: divisible by 4, and not by 100 unless by 400.
    function automatic logic ccpa_is_leap(input logic [YEAR_W-1:0] year);
        logic [2*YEAR_W-1:0] prod;
        logic                div4;
        logic                div16;
        logic                div25;
        prod  = year * YEAR_INV25;
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod[YEAR_W-1:0] <= YEAR_DIV25_LIMIT);
        return div4 && (!div25 || div16);
    endfunction

    // Days in a month; codes past December count as long months.
    function automatic logic [DAY_W-1:0] ccpa_month_len(input logic [MONTH_W-1:0] month,
                                                        input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_FEB)
        begin
            len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end
        else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV})
        begin
            len = DAYS_SHORT;
        end
        else
        begin
            len = DAYS_LONG;
        end
        return len;
    endfunction

endpackage

/* hdl/ccpa_calendar.sv */
// ----------------------------------------------------------------------------
// Calendar time keeper
// Holds seconds through years and works out the time after one request:
// a tick with its carry chain, or a load of all fields.
// ----------------------------------------------------------------------------
`include "calendar_clock_with_periodic_alarms_unit_assert.svh"

module ccpa_calendar (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccpa_pkg::ccpa_ctrl_t ctrl,
    input  ccpa_pkg::ccpa_in_t   req,
    output ccpa_pkg::ccpa_time_t time_after
);
    import ccpa_pkg::*;

    localparam int SEC_SUM_W = SEC_W + 1;
    localparam int MIN_INC_W = MIN_W + 1;
    localparam int HOUR_INC_W = HOUR_W + 1;
    localparam int DAY_INC_W = DAY_W + 1;
    localparam int MONTH_INC_W = MONTH_W + 1;
    localparam int YEAR_INC_W = YEAR_W + 1;

    ccpa_time_t              time_reg;
    ccpa_time_t              time_next;
    ccpa_time_t              time_tick;
    logic [SEC_SUM_W-1:0]    sec_sum;
    logic                    sec_carry;
    logic [MIN_INC_W-1:0]    min_inc;
    logic                    min_carry;
    logic [HOUR_INC_W-1:0]   hour_inc;
    logic                    hour_carry;
    logic [DAY_INC_W-1:0]    day_inc;
    logic [DAY_W-1:0]        month_len;
    logic                    day_roll;
    logic [MONTH_INC_W-1:0]  month_inc;
    logic                    month_carry;
    logic [YEAR_INC_W-1:0]   year_inc;

    // Tick: add the step to the seconds and ripple the carries upward.
    always_comb
    begin
        sec_sum   = {1'b0, time_reg.second} + SEC_SUM_W'(SECONDS_PER_TICK);
        sec_carry = (sec_sum > SEC_SUM_W'(SEC_MAX));
        // A loaded value above 59 plus the step stays below two minutes' worth.
        if (sec_sum >= SEC_SUM_W'(2 * SEC_PER_MIN))
        begin
            time_tick.second = SEC_W'(sec_sum - SEC_SUM_W'(2 * SEC_PER_MIN));
        end
        else if (sec_carry)
        begin
            time_tick.second = SEC_W'(sec_sum - SEC_SUM_W'(SEC_PER_MIN));
        end
        else
        begin
            time_tick.second = sec_sum[SEC_W-1:0];
        end

        min_inc          = {1'b0, time_reg.minute} + MIN_INC_W'(sec_carry);
        min_carry        = (min_inc > MIN_INC_W'(MIN_MAX));
        time_tick.minute = min_carry ? '0 : min_inc[MIN_W-1:0];

        hour_inc         = {1'b0, time_reg.hour} + HOUR_INC_W'(min_carry);
        hour_carry       = (hour_inc > HOUR_INC_W'(HOUR_MAX));
        time_tick.hour   = hour_carry ? '0 : hour_inc[HOUR_W-1:0];

        // The day is checked against the current month on every tick.
        month_len        = ccpa_month_len(time_reg.month, ccpa_is_leap(time_reg.year));
        day_inc          = {1'b0, time_reg.day} + DAY_INC_W'(hour_carry);
        day_roll         = (day_inc >= {1'b0, month_len});
        time_tick.day    = day_roll ? '0 : day_inc[DAY_W-1:0];

        month_inc        = {1'b0, time_reg.month} + MONTH_INC_W'(day_roll);
        month_carry      = (month_inc > MONTH_INC_W'(MONTH_MAX));
        time_tick.month  = month_carry ? '0 : month_inc[MONTH_W-1:0];

        year_inc         = {1'b0, time_reg.year} + YEAR_INC_W'(month_carry);
        time_tick.year   = (year_inc > YEAR_INC_W'(YEAR_MAX)) ? '0 : year_inc[YEAR_W-1:0];
    end

    // Time after the request in the execute stage.
    always_comb
    begin
        if (ctrl.load_time)
        begin
            time_after.second = req.new_second;
            time_after.minute = req.new_minute;
            time_after.hour   = req.new_hour;
            time_after.day    = req.new_day;
            time_after.month  = req.new_month;
            time_after.year   = req.new_year;
        end
        else if (ctrl.tick)
        begin
            time_after = time_tick;
        end
        else
        begin
            time_after = time_reg;
        end
        time_next = ctrl.advance ? time_after : time_reg;
    end

    // Time registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else
        begin
            time_reg <= time_next;
        end
    end

    // Checks that a tick leaves every field in its normal range.
    `CCPA_ASSERT_NEXT(a_tick_in_range, ctrl.advance && ctrl.tick,
        time_reg.second <= SEC_W'(SEC_MAX) && time_reg.minute <= MIN_W'(MIN_MAX) &&
        time_reg.hour <= HOUR_W'(HOUR_MAX) && time_reg.day <= DAY_W'(DAY_MAX) &&
        time_reg.month <= MONTH_W'(MONTH_MAX) && time_reg.year <= YEAR_W'(YEAR_MAX),
        "calendar field out of range after a tick")

    // Collect and unknown operations leave the time alone.
    `CCPA_ASSERT_NEXT(a_hold_time, !ctrl.advance || (!ctrl.tick && !ctrl.load_time),
        time_reg == $past(time_reg), "calendar time changed without a tick or load")

endmodule

/* hdl/ccpa_alarms.sv */
// ----------------------------------------------------------------------------
// Periodic alarm slots
// Enable and interval registers, one tick counter per slot and the pending
// mask that a collect request reports and clears.
// ----------------------------------------------------------------------------
`include "calendar_clock_with_periodic_alarms_unit_assert.svh"

module ccpa_alarms #(
    parameter int NUM_ALARMS = ccpa_pkg::NUM_ALARMS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ccpa_pkg::ccpa_ctrl_t               ctrl,
    input  logic                               cfg_write_en,
    input  logic [ccpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [ccpa_pkg::SLOT_COUNT-1:0]    alarms_fired
);
    import ccpa_pkg::*;

    // Slots past NUM_ALARMS or past the register set are never built.
    localparam int ACTIVE_SLOTS = (NUM_ALARMS < SLOT_COUNT) ? NUM_ALARMS : SLOT_COUNT;
    localparam logic [SLOT_COUNT-1:0] ACTIVE_MASK = SLOT_COUNT'((1 << ACTIVE_SLOTS) - 1);

    logic [SLOT_COUNT-1:0] enable_reg;
    logic [SLOT_COUNT-1:0] enable_next;
    logic [SLOT_COUNT-1:0] pending_reg;
    logic [SLOT_COUNT-1:0] pending_next;
    logic [SLOT_COUNT-1:0] changed;
    logic [SLOT_COUNT-1:0] fire_vec;
    logic                  enable_wr;

    // Enable register write; slots whose bit flips are restarted.
    always_comb
    begin
        enable_wr   = cfg_write_en && (cfg_index == REG_ALARM_ENABLE);
        changed     = enable_wr ? (cfg_data[SLOT_COUNT-1:0] ^ enable_reg) : '0;
        enable_next = enable_wr ? cfg_data[SLOT_COUNT-1:0] : enable_reg;
    end

    // Per-slot interval register and tick counter.
    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_slot
        if (k < ACTIVE_SLOTS)
        begin : g_active
            logic [INTERVAL_W-1:0] interval_reg;
            logic [INTERVAL_W-1:0] interval_next;
            logic [INTERVAL_W-1:0] count_reg;
            logic [INTERVAL_W-1:0] count_next;
            logic [INTERVAL_W-1:0] count_inc;
            logic                  interval_wr;
            logic                  counting;

            assign count_inc   = count_reg + INTERVAL_W'(1);
            assign counting    = ctrl.advance && ctrl.tick && enable_reg[k];
            assign fire_vec[k] = counting && (count_inc >= interval_reg);

            always_comb
            begin
                interval_wr   = cfg_write_en && (cfg_index == CFG_INDEX_W'(REG_INTERVAL_0 + k));
                interval_next = interval_wr ? cfg_data[INTERVAL_W-1:0] : interval_reg;
                if (changed[k])
                begin
                    count_next = '0;
                end
                else if (counting)
                begin
                    count_next = fire_vec[k] ? '0 : count_inc;
                end
                else
                begin
                    count_next = count_reg;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    interval_reg <= '0;
                    count_reg    <= '0;
                end
                else
                begin
                    interval_reg <= interval_next;
                    count_reg    <= count_next;
                end
            end
        end
        else
        begin : g_absent
            assign fire_vec[k] = 1'b0;
        end
    end

    // Pending mask: an enable write drops restarted flags; else collect clears all.
    always_comb
    begin
        pending_next = pending_reg;
        if (enable_wr)
        begin
            pending_next = pending_reg & ~changed;
        end
        else if (ctrl.advance)
        begin
            pending_next = ctrl.collect ? '0 : (pending_reg | fire_vec);
        end
    end

    // A collect reports the mask before it is cleared; a tick includes new firings.
    assign alarms_fired = pending_reg | fire_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            pending_reg <= '0;
        end
        else
        begin
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
        end
    end

    // A slot can only be pending while it is enabled and built.
    `CCPA_ASSERT_IMPLY(a_pending_enabled, 1'b1,
        (pending_reg & ~(enable_reg & ACTIVE_MASK)) == '0,
        "alarm pending on a disabled or absent slot")

    // A collect empties the pending mask.
    `CCPA_ASSERT_NEXT(a_collect_clears, ctrl.advance && ctrl.collect && !cfg_write_en,
        pending_reg == '0, "pending mask not cleared by collect")

endmodule

/* hdl/calendar_clock_with_periodic_alarms_unit.sv */
// ----------------------------------------------------------------------------
// Calendar clock with periodic alarms
// Keeps seconds, minutes, hours, zero-based day and month, and year, and
// counts ticks for up to four periodic alarm slots.
// - Input channel (in_valid, in_stall, in_data) takes one request per
//   cycle while in_stall is low: a tick, a time load, or a collect that
//   reports and clears the pending alarm mask.
// - Every request yields exactly one result on (out_valid, out_stall,
//   out_data): the time after the request and the pending alarm mask.
// - The request lands in the input register; once the result register is
//   free, the update writes the new state and the result register.
// - Throughput is one request per cycle while out_stall is low; each update
//   is one pass of carry and compare logic between input and result registers.
// - When out_stall holds the result, one more request can still be taken
//   into the input register; in_stall rises only when both are full.
// - The configuration port writes the alarm enable and interval registers;
//   write only while no request is in flight.
// - Reset clears the time, the alarm counters, the pending mask and all
//   configuration registers.
// ----------------------------------------------------------------------------
`include "calendar_clock_with_periodic_alarms_unit_assert.svh"

module calendar_clock_with_periodic_alarms_unit #(
    parameter int NUM_ALARMS = ccpa_pkg::NUM_ALARMS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ccpa_pkg::ccpa_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ccpa_pkg::ccpa_out_t               out_data,
    input  logic                              cfg_write_en,
    input  logic [ccpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ccpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ccpa_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    ccpa_in_t              s1_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    ccpa_out_t             out_data_reg;
    ccpa_out_t             result;
    ccpa_ctrl_t            ctrl;
    ccpa_time_t            time_after;
    logic [SLOT_COUNT-1:0] fired;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    // Pipeline flow: the execute step runs when the result register is free.
    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        advance        = s1_valid_reg && out_free;
        in_stall       = s1_valid_reg && !out_free;
        in_take        = in_valid && !in_stall;
        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !out_free);
    end

    // Request decode for the datapath blocks.
    always_comb
    begin
        ctrl.advance   = advance;
        ctrl.tick      = (s1_data_reg.operation == OP_TICK);
        ctrl.load_time = (s1_data_reg.operation == OP_SET_TIME);
        ctrl.collect   = (s1_data_reg.operation == OP_COLLECT);
    end

    ccpa_calendar u_calendar (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .req        (s1_data_reg),
        .time_after (time_after)
    );

    ccpa_alarms #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_alarms (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .alarms_fired (fired)
    );

    // Result assembly.
    always_comb
    begin
        result.second_now   = time_after.second;
        result.minute_now   = time_after.minute;
        result.hour_now     = time_after.hour;
        result.day_now      = time_after.day;
        result.month_now    = time_after.month;
        result.year_now     = time_after.year;
        result.alarms_fired = fired;
    end

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every executed request shows up as a result.
    `CCPA_ASSERT_NEXT(a_result_loaded, advance, out_valid_reg,
        "executed request produced no result")

    // A request waiting for the result register keeps its place and contents.
    `CCPA_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_data_reg), "waiting request lost or changed")

endmodule
